>>> design/smrc_pkg.sv
`default_nettype none

package smrc_pkg;

  localparam int RX_FIFO_DEPTH_DEF = 16;
  localparam int NUM_SELECTS_DEF   = 4;
  localparam int NUM_CS_LINES      = 4;
  localparam int NUM_PLAIN         = 6;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Register offsets
  localparam logic [11:0] OFS_VERSION  = 12'h000;
  localparam logic [11:0] OFS_PARAMS   = 12'h004;
  localparam logic [11:0] OFS_CONTROL  = 12'h010;
  localparam logic [11:0] OFS_STATUS   = 12'h014;
  localparam logic [11:0] OFS_IRQ_EN   = 12'h018;
  localparam logic [11:0] OFS_DMA_EN   = 12'h01C;
  localparam logic [11:0] OFS_PLAIN0   = 12'h020;
  localparam logic [11:0] OFS_PLAIN1   = 12'h024;
  localparam logic [11:0] OFS_PLAIN2   = 12'h030;
  localparam logic [11:0] OFS_PLAIN3   = 12'h034;
  localparam logic [11:0] OFS_PLAIN4   = 12'h040;
  localparam logic [11:0] OFS_PLAIN5   = 12'h044;
  localparam logic [11:0] OFS_FIFO_CTL = 12'h058;
  localparam logic [11:0] OFS_FIFO_ST  = 12'h05C;
  localparam logic [11:0] OFS_CMD      = 12'h060;
  localparam logic [11:0] OFS_TX_DATA  = 12'h064;
  localparam logic [11:0] OFS_RX_STAT  = 12'h070;
  localparam logic [11:0] OFS_RX_DATA  = 12'h074;
  localparam logic [11:0] OFS_RX_PEEK  = 12'h078;

  localparam logic [31:0] VERSION_WORD = 32'h0200_0004;
  localparam logic [31:0] PARAMS_LOW   = 32'h0000_0404;
  localparam logic [31:0] IRQ_MASK     = 32'h0000_3F03;
  localparam logic [31:0] CMD_RESET    = 32'h0000_001F;

  localparam int CTL_ENABLE_BIT    = 0;
  localparam int CTL_CLEAR_ALL_BIT = 1;
  localparam int CTL_CLEAR_RX_BIT  = 9;
  localparam int CMD_TX_MASK_BIT   = 18;
  localparam int CMD_RX_MASK_BIT   = 19;
  localparam int CMD_CONT_BIT      = 21;

  localparam logic [2:0] NO_SELECT = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [11:0] reg_offset;
    logic [31:0] write_data;
    logic [31:0] miso_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        dma_tx_request;
    logic        dma_rx_request;
    logic [3:0]  chip_selects_n;
    logic        shift_valid;
    logic [31:0] mosi_word;
    logic [2:0]  shift_bytes;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_cmd_t;

  function automatic logic [31:0] status_word(input logic [2:0] sticky,
                                              input logic nonempty);
    status_word = {21'd0, sticky, 6'd0, nonempty, 1'b1};
  endfunction

  function automatic logic [2:0] plain_index(input logic [11:0] ofs);
    case (ofs)
      OFS_PLAIN0: plain_index = 3'd0;
      OFS_PLAIN1: plain_index = 3'd1;
      OFS_PLAIN2: plain_index = 3'd2;
      OFS_PLAIN3: plain_index = 3'd3;
      OFS_PLAIN4: plain_index = 3'd4;
      OFS_PLAIN5: plain_index = 3'd5;
      default:    plain_index = 3'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> design/spi_master_register_controller.sv
`default_nettype none

// Channel  Direction  Payload     Handshake
// in       into block in_item_t   in_valid / in_stall
// out      from block out_item_t  out_valid / out_stall
//
// Each access is decoded and applied to the registers and the receive FIFO at
// the accepting edge, and its result sits in the output register from the next
// cycle. One access is accepted per cycle while in_stall is low.
// Reset restores all register-map registers, empties the FIFO and releases chip select.
// in_stall rises only while a result waits in the output register and
// out_stall holds it there.

module spi_master_register_controller #(
  parameter int RX_FIFO_DEPTH = smrc_pkg::RX_FIFO_DEPTH_DEF,
  parameter int NUM_SELECTS   = smrc_pkg::NUM_SELECTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  smrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output smrc_pkg::out_item_t out_data
);
  import smrc_pkg::*;

  localparam int CNT_W = $clog2(RX_FIFO_DEPTH + 1);

  logic        accept;

  logic [3:0]  control;
  logic [2:0]  sticky;
  logic [31:0] irq_en;
  logic [31:0] dma_en;
  logic [31:0] fifo_ctl;
  logic [31:0] xfer_cmd;
  logic [31:0] plain [NUM_PLAIN];
  logic [2:0]  active_sel;

  logic [3:0]  control_next;
  logic [2:0]  sticky_next;
  logic [31:0] irq_en_next;
  logic [31:0] dma_en_next;
  logic [31:0] fifo_ctl_next;
  logic [31:0] xfer_cmd_next;
  logic [2:0]  active_sel_next;
  logic        plain_we;
  logic [2:0]  plain_idx;

  fifo_cmd_t        fcmd;
  logic [31:0]      push_data;
  logic [CNT_W-1:0] fifo_count;
  logic [CNT_W-1:0] count_after;
  logic [31:0]      head_data;

  logic [2:0]  nbytes;
  logic [31:0] keep;
  out_item_t   res;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign plain_idx = plain_index(in_data.reg_offset);

  always_comb begin
    nbytes = (xfer_cmd[11:5] != 7'd0) ? 3'd4 : 3'({1'b0, xfer_cmd[4:3]} + 3'd1);
    case (nbytes)
      3'd1:    keep = 32'h0000_00FF;
      3'd2:    keep = 32'h0000_FFFF;
      3'd3:    keep = 32'h00FF_FFFF;
      default: keep = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    control_next    = control;
    sticky_next     = sticky;
    irq_en_next     = irq_en;
    dma_en_next     = dma_en;
    fifo_ctl_next   = fifo_ctl;
    xfer_cmd_next   = xfer_cmd;
    active_sel_next = active_sel;
    plain_we        = 1'b0;
    fcmd            = '0;
    push_data       = in_data.miso_word & keep;
    res             = '0;

    if (in_data.mode == MODE_READ) begin
      case (in_data.reg_offset)
        OFS_VERSION:  res.read_data = VERSION_WORD;
        OFS_PARAMS:   res.read_data = (32'(NUM_SELECTS) << 16) | PARAMS_LOW;
        OFS_CONTROL:  res.read_data = {28'd0, control};
        OFS_STATUS:   res.read_data = status_word(sticky, fifo_count != '0);
        OFS_IRQ_EN:   res.read_data = irq_en;
        OFS_DMA_EN:   res.read_data = dma_en;
        OFS_PLAIN0, OFS_PLAIN1, OFS_PLAIN2, OFS_PLAIN3, OFS_PLAIN4, OFS_PLAIN5:
          res.read_data = plain[plain_idx];
        OFS_FIFO_CTL: res.read_data = fifo_ctl;
        OFS_FIFO_ST:  res.read_data = 32'(fifo_count) << 16;
        OFS_CMD:      res.read_data = xfer_cmd;
        OFS_RX_STAT:  res.read_data = (fifo_count != '0) ? 32'd0 : 32'd2;
        OFS_RX_DATA: begin
          if (fifo_count != '0) begin
            res.read_data = head_data;
            fcmd.pop      = 1'b1;
          end
        end
        OFS_RX_PEEK: begin
          if (fifo_count != '0) begin
            res.read_data = head_data;
          end
        end
        default: res.read_data = 32'd0;
      endcase
    end else begin
      case (in_data.reg_offset)
        OFS_CONTROL: begin
          control_next = in_data.write_data[3:0];
          if (in_data.write_data[CTL_CLEAR_ALL_BIT]) begin
            sticky_next = 3'd0;
            fcmd.clear  = 1'b1;
          end
          if (in_data.write_data[CTL_CLEAR_RX_BIT]) begin
            fcmd.clear = 1'b1;
          end
        end
        OFS_STATUS:   sticky_next   = sticky & ~in_data.write_data[10:8];
        OFS_IRQ_EN:   irq_en_next   = in_data.write_data;
        OFS_DMA_EN:   dma_en_next   = in_data.write_data;
        OFS_PLAIN0, OFS_PLAIN1, OFS_PLAIN2, OFS_PLAIN3, OFS_PLAIN4, OFS_PLAIN5:
          plain_we = 1'b1;
        OFS_FIFO_CTL: fifo_ctl_next = in_data.write_data;
        OFS_CMD:      xfer_cmd_next = in_data.write_data;
        OFS_TX_DATA: begin
          if (control[CTL_ENABLE_BIT]) begin
            // drop the received word when masked or the FIFO is full
            if (!xfer_cmd[CMD_RX_MASK_BIT] &&
                (32'(fifo_count) < 32'(RX_FIFO_DEPTH))) begin
              fcmd.push = 1'b1;
            end
            if (xfer_cmd[CMD_CONT_BIT]) begin
              active_sel_next = {1'b0, xfer_cmd[25:24]};
              sticky_next     = sticky | 3'b011;
            end else begin
              active_sel_next = NO_SELECT;
              sticky_next     = sticky | 3'b111;
            end
            res.shift_valid = 1'b1;
            res.mosi_word   = xfer_cmd[CMD_TX_MASK_BIT] ? keep
                                                        : (in_data.write_data & keep);
            res.shift_bytes = nbytes;
          end
        end
        default: ;
      endcase
    end

    if (!accept) begin
      fcmd = '0;
    end

    if (fcmd.clear) begin
      count_after = '0;
    end else if (fcmd.pop) begin
      count_after = fifo_count - CNT_W'(1);
    end else if (fcmd.push) begin
      count_after = fifo_count + CNT_W'(1);
    end else begin
      count_after = fifo_count;
    end

    res.irq_level = (status_word(sticky_next, count_after != '0) & irq_en_next
                     & IRQ_MASK) != 32'd0;
    res.dma_tx_request = control_next[CTL_ENABLE_BIT] && dma_en_next[0];
    res.dma_rx_request = control_next[CTL_ENABLE_BIT] && dma_en_next[1] &&
                         (32'(count_after) > 32'(fifo_ctl_next[19:16]));
    for (int n = 0; n < NUM_CS_LINES; n++) begin
      res.chip_selects_n[n] = !((n < NUM_SELECTS) && (active_sel_next == 3'(n)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control    <= '0;
      sticky     <= '0;
      irq_en     <= '0;
      dma_en     <= '0;
      fifo_ctl   <= '0;
      xfer_cmd   <= CMD_RESET;
      active_sel <= NO_SELECT;
      for (int i = 0; i < NUM_PLAIN; i++) begin
        plain[i] <= '0;
      end
    end else if (accept) begin
      control    <= control_next;
      sticky     <= sticky_next;
      irq_en     <= irq_en_next;
      dma_en     <= dma_en_next;
      fifo_ctl   <= fifo_ctl_next;
      xfer_cmd   <= xfer_cmd_next;
      active_sel <= active_sel_next;
      if (plain_we) begin
        plain[plain_idx] <= in_data.write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  smrc_rx_fifo #(
    .RX_FIFO_DEPTH(RX_FIFO_DEPTH)
  ) u_rx_fifo (
    .clk       (clk),
    .rst       (rst),
    .cmd       (fcmd),
    .push_data (push_data),
    .count     (fifo_count),
    .head_data (head_data)
  );

endmodule

`default_nettype wire

>>> design/smrc_rx_fifo.sv
`default_nettype none

module smrc_rx_fifo #(
  parameter int RX_FIFO_DEPTH = smrc_pkg::RX_FIFO_DEPTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  smrc_pkg::fifo_cmd_t                  cmd,
  input  wire [31:0]                           push_data,
  output logic [$clog2(RX_FIFO_DEPTH+1)-1:0]   count,
  output logic [31:0]                          head_data
);
  import smrc_pkg::*;

  localparam int PTR_W = $clog2(RX_FIFO_DEPTH);
  localparam int CNT_W = $clog2(RX_FIFO_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [31:0]      mem [RX_FIFO_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [CNT_W-1:0] count_next;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail;

  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    // head + count stays below twice the depth: one subtract wraps it
    if (tail_sum >= SUM_W'(RX_FIFO_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(RX_FIFO_DEPTH);
    end
    tail = tail_sum[PTR_W-1:0];
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    if (cmd.clear) begin
      head_next  = '0;
      count_next = '0;
    end else if (cmd.pop) begin
      head_next  = (head == PTR_W'(RX_FIFO_DEPTH - 1)) ? '0 : head + PTR_W'(1);
      count_next = count - CNT_W'(1);
    end else if (cmd.push) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Keep the word at the head registered; bypass a push that lands there
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= push_data;
    end
    if (cmd.push && (tail == head_next)) begin
      head_data <= push_data;
    end else begin
      head_data <= mem[head_next];
    end
  end

endmodule

`default_nettype wire

>>> dv/smrc_access_checker.sv
module smrc_access_checker (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  smrc_pkg::in_item_t   in_data,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  smrc_pkg::out_item_t  out_data,
  output int                   mismatches,
  output int                   awaiting
);
  import smrc_pkg::*;

  logic [3:0]  ctl_r;
  logic [2:0]  sticky_r;
  logic [31:0] irq_en_r;
  logic [31:0] dma_en_r;
  logic [31:0] fifo_ctl_r;
  logic [31:0] cmd_r;
  logic [31:0] plain_r [NUM_PLAIN];
  logic [31:0] rx_mem [RX_FIFO_DEPTH_DEF];
  logic [3:0]  rx_head;
  logic [4:0]  rx_fill;
  logic [2:0]  sel_r;

  out_item_t reply_queue [$];
  out_item_t want;
  out_item_t rep;
  int        err_n;

  task automatic compute_reply(input in_item_t it, output out_item_t r);
    logic [31:0] st;
    logic [31:0] keep;
    logic [3:0]  slot;
    int          nb;
    r = '0;
    if (it.mode == MODE_READ) begin
      case (it.reg_offset)
        OFS_VERSION:  r.read_data = VERSION_WORD;
        OFS_PARAMS:   r.read_data = (32'(NUM_SELECTS_DEF) << 16) | PARAMS_LOW;
        OFS_CONTROL:  r.read_data = {28'd0, ctl_r};
        OFS_STATUS:   r.read_data = {21'd0, sticky_r, 6'd0, rx_fill != 5'd0, 1'b1};
        OFS_IRQ_EN:   r.read_data = irq_en_r;
        OFS_DMA_EN:   r.read_data = dma_en_r;
        OFS_PLAIN0:   r.read_data = plain_r[0];
        OFS_PLAIN1:   r.read_data = plain_r[1];
        OFS_PLAIN2:   r.read_data = plain_r[2];
        OFS_PLAIN3:   r.read_data = plain_r[3];
        OFS_PLAIN4:   r.read_data = plain_r[4];
        OFS_PLAIN5:   r.read_data = plain_r[5];
        OFS_FIFO_CTL: r.read_data = fifo_ctl_r;
        OFS_FIFO_ST:  r.read_data = {11'd0, rx_fill, 16'd0};
        OFS_CMD:      r.read_data = cmd_r;
        OFS_RX_STAT:  r.read_data = (rx_fill != 5'd0) ? 32'd0 : 32'd2;
        OFS_RX_DATA, OFS_RX_PEEK: begin
          // empty FIFO reads zero and pops nothing
          if (rx_fill != 5'd0) begin
            r.read_data = rx_mem[rx_head];
            if (it.reg_offset == OFS_RX_DATA) begin
              rx_head = rx_head + 4'd1;
              rx_fill = rx_fill - 5'd1;
            end
          end
        end
        default:      r.read_data = 32'd0;
      endcase
    end else begin
      case (it.reg_offset)
        OFS_PLAIN0:   plain_r[0] = it.write_data;
        OFS_PLAIN1:   plain_r[1] = it.write_data;
        OFS_PLAIN2:   plain_r[2] = it.write_data;
        OFS_PLAIN3:   plain_r[3] = it.write_data;
        OFS_PLAIN4:   plain_r[4] = it.write_data;
        OFS_PLAIN5:   plain_r[5] = it.write_data;
        OFS_CONTROL: begin
          ctl_r = it.write_data[3:0];
          if (it.write_data[CTL_CLEAR_ALL_BIT]) begin
            sticky_r = 3'd0;
            rx_head  = 4'd0;
            rx_fill  = 5'd0;
          end
          if (it.write_data[CTL_CLEAR_RX_BIT]) begin
            rx_head = 4'd0;
            rx_fill = 5'd0;
          end
        end
        OFS_STATUS:   sticky_r = sticky_r & ~it.write_data[10:8];
        OFS_IRQ_EN:   irq_en_r = it.write_data;
        OFS_DMA_EN:   dma_en_r = it.write_data;
        OFS_FIFO_CTL: fifo_ctl_r = it.write_data;
        OFS_CMD:      cmd_r = it.write_data;
        OFS_TX_DATA: begin
          if (ctl_r[CTL_ENABLE_BIT]) begin
            // frame size saturates at four bytes
            nb = (int'(cmd_r[11:0]) + 8) / 8;
            if (nb > 4)
              nb = 4;
            keep  = (nb == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nb)) - 32'd1);
            sel_r = {1'b0, cmd_r[25:24]};
            if (!cmd_r[CMD_RX_MASK_BIT] && rx_fill < 5'(RX_FIFO_DEPTH_DEF)) begin
              slot         = rx_head + rx_fill[3:0];
              rx_mem[slot] = it.miso_word & keep;
              rx_fill      = rx_fill + 5'd1;
            end
            sticky_r = sticky_r | 3'b011;
            if (!cmd_r[CMD_CONT_BIT]) begin
              sel_r       = NO_SELECT;
              sticky_r[2] = 1'b1;
            end
            r.shift_valid = 1'b1;
            r.mosi_word   = cmd_r[CMD_TX_MASK_BIT] ? keep : (it.write_data & keep);
            r.shift_bytes = 3'(nb);
          end
        end
        default: ;
      endcase
    end
    st = {21'd0, sticky_r, 6'd0, rx_fill != 5'd0, 1'b1};
    r.irq_level      = |(st & irq_en_r & IRQ_MASK);
    r.dma_tx_request = ctl_r[CTL_ENABLE_BIT] & dma_en_r[0];
    r.dma_rx_request = ctl_r[CTL_ENABLE_BIT] & dma_en_r[1] &
                       (rx_fill > {1'b0, fifo_ctl_r[19:16]});
    r.chip_selects_n = 4'hF;
    for (int n = 0; n < NUM_CS_LINES; n++)
      if (n < NUM_SELECTS_DEF && sel_r == 3'(n))
        r.chip_selects_n[n] = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ctl_r      = 4'd0;
      sticky_r   = 3'd0;
      irq_en_r   = 32'd0;
      dma_en_r   = 32'd0;
      fifo_ctl_r = 32'd0;
      cmd_r      = CMD_RESET;
      for (int i = 0; i < NUM_PLAIN; i++)
        plain_r[i] = 32'd0;
      rx_head = 4'd0;
      rx_fill = 5'd0;
      sel_r   = NO_SELECT;
      reply_queue.delete();
      err_n = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_queue.size() == 0) begin
          err_n++;
          if (err_n <= 10)
            $display("unexpected reply at %0t: %h", $realtime, out_data);
        end else begin
          want = reply_queue.pop_front();
          if (out_data.read_data      !== want.read_data      ||
              out_data.irq_level      !== want.irq_level      ||
              out_data.dma_tx_request !== want.dma_tx_request ||
              out_data.dma_rx_request !== want.dma_rx_request ||
              out_data.chip_selects_n !== want.chip_selects_n ||
              out_data.shift_valid    !== want.shift_valid    ||
              out_data.mosi_word      !== want.mosi_word      ||
              out_data.shift_bytes    !== want.shift_bytes) begin
            err_n++;
            if (err_n <= 10) begin
              $display("reply mismatch at %0t", $realtime);
              $display("  want rd=%h irq=%b dtx=%b drx=%b cs=%h sv=%b mosi=%h nb=%0d",
                       want.read_data, want.irq_level, want.dma_tx_request,
                       want.dma_rx_request, want.chip_selects_n, want.shift_valid,
                       want.mosi_word, want.shift_bytes);
              $display("  got  rd=%h irq=%b dtx=%b drx=%b cs=%h sv=%b mosi=%h nb=%0d",
                       out_data.read_data, out_data.irq_level, out_data.dma_tx_request,
                       out_data.dma_rx_request, out_data.chip_selects_n,
                       out_data.shift_valid, out_data.mosi_word, out_data.shift_bytes);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        compute_reply(in_data, rep);
        reply_queue.push_back(rep);
      end
    end
    mismatches <= err_n;
    awaiting   <= reply_queue.size();
  end

endmodule

>>> dv/spi_master_register_controller_tb.sv
module spi_master_register_controller_tb;
  import smrc_pkg::*;

  localparam int N_RAND = 1880;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        mismatches;
  int        awaiting;
  bit        idle_on   = 1'b1;
  int        stall_left;
  int        n_reads;
  int        n_writes;
  int        n_tx;

  spi_master_register_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  smrc_access_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always #5 clk = ~clk;

  // receiver holds off in random bursts while idling is enabled
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic bus_access(input logic m, input logic [11:0] ofs,
                            input logic [31:0] wd, input logic [31:0] ms);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: m, reg_offset: ofs, write_data: wd, miso_word: ms};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (m == MODE_READ)
      n_reads++;
    else
      n_writes++;
    if (m == MODE_WRITE && ofs == OFS_TX_DATA)
      n_tx++;
  endtask

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int          kind;
    logic        m;
    logic [11:0] ofs;
    logic [31:0] wd;
    n_reads  = 0;
    n_writes = 0;
    n_tx     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, empty FIFO, transmit while disabled
    bus_access(MODE_READ,  OFS_VERSION, 32'h0, 32'h0);
    bus_access(MODE_READ,  OFS_PARAMS,  32'h0, 32'h0);
    bus_access(MODE_READ,  OFS_STATUS,  32'h0, 32'h0);
    bus_access(MODE_READ,  OFS_CMD,     32'h0, 32'h0);
    bus_access(MODE_READ,  OFS_RX_DATA, 32'h0, 32'h0);
    bus_access(MODE_READ,  OFS_RX_PEEK, 32'h0, 32'h0);
    bus_access(MODE_WRITE, OFS_TX_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    bus_access(MODE_WRITE, OFS_CONTROL, 32'h1, 32'h0);
    bus_access(MODE_WRITE, OFS_IRQ_EN,  32'hFFFF_FFFF, 32'h0);
    bus_access(MODE_WRITE, OFS_DMA_EN,  32'hFFFF_FFFF, 32'h0);
    bus_access(MODE_WRITE, OFS_FIFO_CTL, 32'h0, 32'h0);
    // one byte, select 3, continuous
    bus_access(MODE_WRITE, OFS_CMD,     32'h0320_0007, 32'h0);
    bus_access(MODE_WRITE, OFS_TX_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // oversized frame, transmit masked, select 0, frame ends
    bus_access(MODE_WRITE, OFS_CMD,     32'h0004_0FFF, 32'h0);
    bus_access(MODE_WRITE, OFS_TX_DATA, 32'h0, 32'h0);
    // three bytes, receive masked, select 1, continuous
    bus_access(MODE_WRITE, OFS_CMD,     32'h0128_0017, 32'h0);
    bus_access(MODE_WRITE, OFS_TX_DATA, 32'hA5A5_A5A5, 32'h1234_5678);
    bus_access(MODE_READ,  OFS_RX_PEEK, 32'h0, 32'h0);
    bus_access(MODE_READ,  OFS_RX_DATA, 32'h0, 32'h0);
    bus_access(MODE_WRITE, OFS_STATUS,  32'h0000_0700, 32'h0);
    bus_access(MODE_READ,  OFS_STATUS,  32'h0, 32'h0);
    bus_access(MODE_WRITE, OFS_PLAIN0,  32'hFFFF_FFFF, 32'h0);
    bus_access(MODE_READ,  12'h021,     32'h0, 32'h0);
    bus_access(MODE_WRITE, OFS_VERSION, 32'h0, 32'h0);
    bus_access(MODE_READ,  12'hFFF,     32'h0, 32'h0);
    bus_access(MODE_WRITE, OFS_CONTROL, 32'h0000_0202, 32'h0);
    bus_access(MODE_WRITE, OFS_CONTROL, 32'h0000_0201, 32'h0);

    for (int k = 0; k < N_RAND; k++) begin
      idle_on <= (k < N_RAND - 200) && ((k % 400) < 300);
      kind = $urandom_range(0, 99);
      m    = MODE_WRITE;
      wd   = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF :
             (($urandom_range(0, 9) == 0) ? 32'h0 : $urandom);
      if (kind < 25) begin
        ofs = OFS_TX_DATA;
      end else if (kind < 35) begin
        m   = MODE_READ;
        ofs = OFS_RX_DATA;
      end else if (kind < 40) begin
        m   = MODE_READ;
        ofs = OFS_RX_PEEK;
      end else if (kind < 45) begin
        ofs = OFS_CMD;
        wd  = $urandom;
        case ($urandom_range(0, 3))
          0, 1:    wd[11:0] = 12'($urandom_range(0, 31));
          2:       wd[11:0] = 12'hFFF;
          default: ;
        endcase
        wd[CMD_RX_MASK_BIT] = ($urandom_range(0, 3) == 0);
      end else if (kind < 50) begin
        // keep the block enabled most of the time, clear rarely
        ofs = OFS_CONTROL;
        wd  = $urandom;
        wd[CTL_ENABLE_BIT]    = ($urandom_range(0, 6) != 0);
        wd[CTL_CLEAR_ALL_BIT] = ($urandom_range(0, 9) == 0);
        wd[CTL_CLEAR_RX_BIT]  = ($urandom_range(0, 9) == 0);
      end else if (kind < 54) begin
        ofs = OFS_STATUS;
      end else if (kind < 58) begin
        case ($urandom_range(0, 2))
          0:       ofs = OFS_IRQ_EN;
          1:       ofs = OFS_DMA_EN;
          default: ofs = OFS_FIFO_CTL;
        endcase
      end else if (kind < 93) begin
        m = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 18))
          0:       ofs = OFS_VERSION;
          1:       ofs = OFS_PARAMS;
          2:       ofs = OFS_CONTROL;
          3:       ofs = OFS_STATUS;
          4:       ofs = OFS_IRQ_EN;
          5:       ofs = OFS_DMA_EN;
          6:       ofs = OFS_PLAIN0;
          7:       ofs = OFS_PLAIN1;
          8:       ofs = OFS_PLAIN2;
          9:       ofs = OFS_PLAIN3;
          10:      ofs = OFS_PLAIN4;
          11:      ofs = OFS_PLAIN5;
          12:      ofs = OFS_FIFO_CTL;
          13:      ofs = OFS_FIFO_ST;
          14:      ofs = OFS_CMD;
          15:      ofs = OFS_TX_DATA;
          16:      ofs = OFS_RX_STAT;
          17:      ofs = OFS_RX_DATA;
          default: ofs = OFS_RX_PEEK;
        endcase
        // make turning the block off through the random register path less likely
        if (m == MODE_WRITE && ofs == OFS_CONTROL)
          wd[CTL_ENABLE_BIT] = ($urandom_range(0, 3) != 0);
      end else begin
        m   = 1'($urandom_range(0, 1));
        ofs = 12'($urandom_range(0, 4095));
      end
      bus_access(m, ofs, wd, $urandom);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d accesses: %0d reads, %0d writes, %0d transmit-data writes",
             n_reads + n_writes, n_reads, n_writes, n_tx);
    $display("random idling on both channels, with idle-free stretches and tail");
    if (mismatches == 0 && awaiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
